// File: hdl/crc32rt_pkg.sv
// Package for the CRC-32 radix tag generator.
// Holds CRC constants, digit bases, sequencer states and the symbol lookup.
// No dependencies.
`default_nettype none

package crc32rt_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [7:0] LETTER_BASE = 8'd26;
    localparam logic [7:0] SYMBOL_BASE = 8'd83;
    localparam logic [7:0] LETTER_A    = 8'h41;

    localparam logic [2:0] LETTER_LAST_POS = 3'd5;
    localparam logic [2:0] SYMBOL_LAST_POS = 3'd4;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned REM_W  = 7;

    // quotient = (value * recip) >> shift, exact for any 32-bit value
    localparam logic [31:0] LETTER_RECIP = 32'd2643056798;
    localparam logic [31:0] SYMBOL_RECIP = 32'd3311782012;
    localparam int unsigned LETTER_SHIFT = 36;
    localparam int unsigned SYMBOL_SHIFT = 38;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic mode;
    } t_div_ctl;

    function automatic logic [7:0] symbol_char(input logic [REM_W-1:0] idx);
        logic [7:0] wide;
        logic [7:0] ch;
        wide = {1'b0, idx};
        if (wide >= 8'd10 && wide <= 8'd19) begin
            ch = 8'(wide + 8'h26);
        end else if (wide >= 8'd25 && wide <= 8'd50) begin
            ch = 8'(wide + 8'h28);
        end else if (wide >= 8'd55 && wide <= 8'd80) begin
            ch = 8'(wide + 8'h2A);
        end else begin
            case (wide)
                8'd0:    ch = 8'h21;
                8'd1:    ch = 8'h22;
                8'd2:    ch = 8'h24;
                8'd3:    ch = 8'h26;
                8'd4:    ch = 8'h27;
                8'd5:    ch = 8'h2A;
                8'd6:    ch = 8'h2B;
                8'd7:    ch = 8'h2C;
                8'd8:    ch = 8'h2D;
                8'd9:    ch = 8'h2E;
                8'd20:   ch = 8'h3A;
                8'd21:   ch = 8'h3B;
                8'd22:   ch = 8'h3D;
                8'd23:   ch = 8'h3F;
                8'd24:   ch = 8'h40;
                8'd51:   ch = 8'h5C;
                8'd52:   ch = 8'h5E;
                8'd53:   ch = 8'h5F;
                8'd54:   ch = 8'h60;
                8'd81:   ch = 8'h7C;
                8'd82:   ch = 8'h7E;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hdl/crc32_radix_tag_generator_unit.sv
// Top level of the CRC-32 radix tag generator: stream ports, sequencer, output register.
// Depends on crc32rt_pkg, crc32rt_crc and crc32rt_div.
//
// channel   dir  tdata                            tuser     tlast
// s_axis    in   [7:0] data_byte                  has_byte  end_of_message
// m_axis    out  [7:0] tag_char, [10:8] char_pos  -         last_char
// cfg       in   i_cfg_wdata = alphabet_mode (write on i_cfg_we)
//
// Bytes without end of message: one item per cycle.
// Item with end of message: each tag digit passes the shared divider's multiply,
// remainder and done registers, then is output; 6 or 5 digits before the next item.
// Synchronous active-low reset; crc returns to all ones, mode to letters.
// A stalled output holds the sequencer in place.
`default_nettype none

module crc32_radix_tag_generator_unit
    import crc32rt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [7:0] tag_char, [10:8] char_position
    output logic             m_axis_tlast
);

    t_state            r_state;
    t_state            n_state;
    logic              r_mode;
    logic [7:0]        r_char;
    logic [2:0]        r_pos;
    logic              r_last;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_clear;
    logic [31:0]       w_crc_next;
    t_div_ctl          w_div_ctl;
    logic [WORD_W-1:0] w_div_value;
    logic              w_div_done;
    logic [WORD_W-1:0] w_quotient;
    logic [REM_W-1:0]  w_remainder;
    logic [7:0]        w_char;
    logic [2:0]        w_last_pos;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_clear   = w_in_acc && s_axis_tlast;

    crc32rt_crc u_crc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_absorb   (w_in_acc && s_axis_tuser),
        .i_clear    (w_clear),
        .i_byte     (s_axis_tdata),
        .o_crc_next (w_crc_next)
    );

    crc32rt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_div_ctl),
        .i_value     (w_div_value),
        .o_done      (w_div_done),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    assign w_last_pos  = r_mode ? SYMBOL_LAST_POS : LETTER_LAST_POS;
    assign w_char      = r_mode ? symbol_char(w_remainder)
                                : 8'(LETTER_A + {1'b0, w_remainder});
    assign w_div_value = (r_state == ST_IDLE) ? ~w_crc_next : w_quotient;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_clear) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_axis_tready) n_state = r_last ? ST_IDLE : ST_DIV;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = 1'b0;
        m_axis_tvalid   = 1'b0;
        w_div_ctl.start = 1'b0;
        w_div_ctl.mode  = r_mode;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready   = 1'b1;
                w_div_ctl.start = s_axis_tvalid && s_axis_tlast;
            end
            ST_DIV: begin
            end
            ST_EMIT: begin
                m_axis_tvalid   = 1'b1;
                w_div_ctl.start = m_axis_tready && !r_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (w_clear) begin
                r_pos <= '0;
            end else if (w_out_acc) begin
                r_pos <= 3'(r_pos + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_char <= w_char;
            r_last <= (r_pos == w_last_pos);
        end
    end

    assign m_axis_tdata = {5'b0, r_pos, r_char};
    assign m_axis_tlast = r_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output sides open together");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> r_pos == w_last_pos)
        else $error("last item at wrong position");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside a digit step");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && m_axis_tlast |=> s_axis_tready)
        else $error("no return to input after tag");

endmodule

`default_nettype wire

// File: hdl/crc32rt_crc.sv
// CRC-32 register with byte-wide update, one byte per cycle.
// Depends on crc32rt_pkg.
`default_nettype none

module crc32rt_crc
    import crc32rt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_absorb,
    input  wire logic        i_clear,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc_next
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    always_comb begin
        n_crc = r_crc ^ {24'h0, i_byte};
        for (int k = 0; k < 8; k++) begin
            n_crc = n_crc[0] ? ((n_crc >> 1) ^ CRC_POLY) : (n_crc >> 1);
        end
    end

    assign o_crc_next = i_absorb ? n_crc : r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_clear) begin
            r_crc <= CRC_INIT;
        end else if (i_absorb) begin
            r_crc <= n_crc;
        end
    end

endmodule

`default_nettype wire

// File: hdl/crc32rt_div.sv
// Shared radix divider: reciprocal multiply for the quotient, then the remainder,
// one digit at a time through the multiply, remainder and done registers.
// Depends on crc32rt_pkg.
`default_nettype none

module crc32rt_div
    import crc32rt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_ctl          i_ctl,
    input  wire logic [WORD_W-1:0] i_value,
    output logic                   o_done,
    output logic      [WORD_W-1:0] o_quotient,
    output logic      [REM_W-1:0]  o_remainder
);

    logic                r_mul_go;
    logic                r_rem_go;
    logic                r_done;
    logic [WORD_W-1:0]   r_val;
    logic [WORD_W-1:0]   r_quo;
    logic [REM_W-1:0]    r_rem;
    logic [WORD_W-1:0]   w_recip;
    logic [2*WORD_W-1:0] w_prod;
    logic [WORD_W-1:0]   w_quo;
    logic [REM_W-1:0]    w_base;
    logic [REM_W-1:0]    w_qd;
    logic [REM_W-1:0]    w_rem;

    assign w_recip = i_ctl.mode ? SYMBOL_RECIP : LETTER_RECIP;
    assign w_prod  = {{WORD_W{1'b0}}, r_val} * {{WORD_W{1'b0}}, w_recip};
    assign w_quo   = i_ctl.mode ? WORD_W'(w_prod >> SYMBOL_SHIFT)
                                : WORD_W'(w_prod >> LETTER_SHIFT);
    assign w_base  = i_ctl.mode ? REM_W'(SYMBOL_BASE) : REM_W'(LETTER_BASE);
    assign w_qd    = REM_W'(r_quo[REM_W-1:0] * w_base);
    assign w_rem   = REM_W'(r_val[REM_W-1:0] - w_qd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go <= 1'b0;
            r_rem_go <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_mul_go <= i_ctl.start;
            r_rem_go <= r_mul_go;
            r_done   <= r_rem_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_val <= i_value;
        end
        if (r_mul_go) begin
            r_quo <= w_quo;
        end
        if (r_rem_go) begin
            r_rem <= w_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire
